### rtl/core/particle_contact_impulse_defines.svh
// ----------------------------------------------------------------------------
// particle_contact_impulse assertion macros
// Shared property wrappers for the contact impulse checkers.
// ----------------------------------------------------------------------------
`ifndef PARTICLE_CONTACT_IMPULSE_DEFINES_SVH
`define PARTICLE_CONTACT_IMPULSE_DEFINES_SVH

// same-cycle implication, quiet during reset
`define PCI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define PCI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/pci_pkg.sv
// ----------------------------------------------------------------------------
// pci_pkg
// Types and constants of the particle contact impulse pipeline.
// ----------------------------------------------------------------------------
package pci_pkg;

  localparam int unsigned QBITS   = 37;  // quotient bits = impulse width
  localparam int unsigned NFRONT  = 6;   // stages ahead of the divider
  localparam int unsigned NBACK   = 3;   // stages after the divider
  localparam int unsigned NST     = NFRONT + QBITS + NBACK;
  localparam logic [16:0] ONE_Q15 = 17'd32768;

  // request context carried down the pipe
  typedef struct packed {
    logic signed [31:0] vax;
    logic signed [31:0] vay;
    logic signed [31:0] vbx;
    logic signed [31:0] vby;
    logic        [31:0] ima;
    logic        [32:0] tot;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic               second;
    logic               take;
    logic [QBITS-1:0]   dv;
  } pci_ctx_t;

  // restoring divider state
  typedef struct packed {
    pci_ctx_t         ctx;
    logic [32:0]      rem;
    logic [QBITS-1:0] low;
    logic [QBITS-1:0] quo;
  } pci_div_t;

endpackage

### rtl/core/pci_div_cell.sv
// ----------------------------------------------------------------------------
// pci_div_cell
// One restoring division step: one quotient bit, registered.
// ----------------------------------------------------------------------------
module pci_div_cell (
  input  logic              clk,
  input  logic              en,
  input  pci_pkg::pci_div_t d,
  output pci_pkg::pci_div_t q
);

  logic [33:0] trial;
  logic [33:0] diff;
  logic        fits;

  always_comb begin
    trial = {d.rem, d.low[pci_pkg::QBITS-1]};
    diff  = trial - {1'b0, d.ctx.tot};
    fits  = trial >= {1'b0, d.ctx.tot};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q.ctx <= d.ctx;
      q.rem <= fits ? diff[32:0] : trial[32:0];
      q.low <= {d.low[pci_pkg::QBITS-2:0], 1'b0};
      q.quo <= {d.quo[pci_pkg::QBITS-2:0], fits};
    end
  end

endmodule

### rtl/core/particle_contact_impulse.sv
// ----------------------------------------------------------------------------
// particle_contact_impulse
// Restitution impulse for one 2D particle contact per request.
// ----------------------------------------------------------------------------
//  channel  signals                        direction  notes
//  req      req_valid / req_stall + fields in         one contact per request
//  rsp      rsp_valid / rsp_stall + fields out        one result per request
//  cfg      cfg_valid / cfg_ready / cfg_data in       restitution, Q1.15
//
//  One request per cycle sustained while rsp_stall is low; the pipe has 6 front
//  stages, 37 divider cells at one quotient bit each and 3 back stages.
//  Each stage moves when it is empty or the stage after it moves, so a stalled
//  result does not stop requests from filling empty stages behind it.
//  rst is synchronous: clears stage valid bits and restitution.
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
module particle_contact_impulse (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic signed [31:0] vel_a_x,
  input  logic signed [31:0] vel_a_y,
  input  logic signed [31:0] vel_b_x,
  input  logic signed [31:0] vel_b_y,
  input  logic        [31:0] inv_mass_a,
  input  logic        [31:0] inv_mass_b,
  input  logic signed [15:0] normal_x,
  input  logic signed [15:0] normal_y,
  input  logic               has_second,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic signed [31:0] new_vel_a_x,
  output logic signed [31:0] new_vel_a_y,
  output logic signed [31:0] new_vel_b_x,
  output logic signed [31:0] new_vel_b_y,
  output logic               impulse_applied,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic        [15:0] cfg_data
);

  localparam int unsigned NST = pci_pkg::NST;
  localparam int unsigned QB  = pci_pkg::QBITS;
  localparam int unsigned C0  = pci_pkg::NFRONT;   // first divider cell
  localparam int unsigned B0  = C0 + QB;           // first back stage

  logic [15:0]    restitution;
  logic [NST-1:0] v;
  logic [NST-1:0] en;

  // Per-stage contexts ahead of the divider
  pci_pkg::pci_ctx_t ctx [pci_pkg::NFRONT-1];
  pci_pkg::pci_div_t div [QB+1];

  // front temporaries
  logic signed [32:0] dx, dy;
  logic signed [48:0] px, py;
  logic        [35:0] m16;
  logic        [52:0] plo, phi;

  // back temporaries
  pci_pkg::pci_ctx_t  bctx [2];
  logic [QB-1:0]      sa, sb;
  logic signed [40:0] dax, day, dbx, dby;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      restitution <= '0;
    end else if (cfg_valid) begin
      restitution <= cfg_data;
    end
  end

  // --- stage advance: a stage moves when empty or when its successor moves
  always_comb begin
    en[NST-1] = !v[NST-1] || !rsp_stall;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign req_stall = !en[0];
  assign rsp_valid = v[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= req_valid;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  // --- stage 0: mask the absent body, relative velocity, total inverse mass
  always_ff @(posedge clk) begin
    if (en[0]) begin
      ctx[0].vax    <= vel_a_x;
      ctx[0].vay    <= vel_a_y;
      ctx[0].vbx    <= has_second ? vel_b_x : '0;
      ctx[0].vby    <= has_second ? vel_b_y : '0;
      ctx[0].ima    <= inv_mass_a;
      ctx[0].tot    <= {1'b0, inv_mass_a} + {1'b0, (has_second ? inv_mass_b : 32'd0)};
      ctx[0].nx     <= normal_x;
      ctx[0].ny     <= normal_y;
      ctx[0].second <= has_second;
      ctx[0].take   <= 1'b0;
      ctx[0].dv     <= '0;
      dx <= 33'(vel_a_x) - (has_second ? 33'(vel_b_x) : 33'sd0);
      dy <= 33'(vel_a_y) - (has_second ? 33'(vel_b_y) : 33'sd0);
    end
  end

  // --- stage 1: products with the normal (Q.30)
  always_ff @(posedge clk) begin
    if (en[1]) begin
      ctx[1] <= ctx[0];
      px     <= dx * 49'(ctx[0].nx);
      py     <= dy * 49'(ctx[0].ny);
    end
  end

  // --- stage 2: separating velocity, decision, closing speed in Q.16
  logic signed [49:0] sep;
  logic        [49:0] neg;
  pci_pkg::pci_ctx_t  ctx_take;
  always_comb begin
    sep = 50'(px) + 50'(py);
    neg = 50'(-sep);
    ctx_take      = ctx[1];
    ctx_take.take = (sep <= 50'sd0) && (ctx[1].tot != '0);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      ctx[2] <= ctx_take;
      m16    <= neg[49:14];
    end
  end

  // --- stage 3: dv = closing speed * (1 + e)
  logic [16:0] fac;
  logic [52:0] dvp;
  pci_pkg::pci_ctx_t ctx_dv;
  always_comb begin
    fac = 17'(restitution) + pci_pkg::ONE_Q15;
    dvp = 53'(m16) * 53'(fac);
    ctx_dv    = ctx[2];
    ctx_dv.dv = dvp[51:15];
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      ctx[3] <= ctx_dv;
    end
  end

  // --- stage 4: dv * inv_mass_a in two 16-bit halves
  always_ff @(posedge clk) begin
    if (en[4]) begin
      ctx[4] <= ctx[3];
      plo    <= 53'(ctx[3].dv) * 53'(ctx[3].ima[15:0]);
      phi    <= 53'(ctx[3].dv) * 53'(ctx[3].ima[31:16]);
    end
  end

  // --- stage 5: numerator assembly, divider seed
  // dv*ima < 2^37 * tot, so the top bits start below the divisor
  logic [68:0] num;
  always_comb begin
    num = (69'(phi) << 16) + 69'(plo);
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      div[0].ctx <= ctx[4];
      div[0].rem <= {1'b0, num[68:QB]};
      div[0].low <= num[QB-1:0];
      div[0].quo <= '0;
    end
  end

  // --- divider chain: one quotient bit per cell
  for (genvar i = 0; i < QB; i++) begin : g_cell
    pci_div_cell u_cell (
      .clk (clk),
      .en  (en[C0+i]),
      .d   (div[i]),
      .q   (div[i+1])
    );
  end

  // --- back 0: shares; s_b = dv - s_a - (remainder != 0) is the floor of B's part
  always_ff @(posedge clk) begin
    if (en[B0]) begin
      bctx[0] <= div[QB].ctx;
      sa      <= div[QB].quo;
      sb      <= div[QB].ctx.dv - div[QB].quo - QB'(div[QB].rem != '0);
    end
  end

  // --- back 1: per-component changes, truncated toward zero
  logic [15:0] anx, any;
  logic [52:0] pax, pay, pbx, pby;
  always_comb begin
    anx = bctx[0].nx[15] ? 16'(-bctx[0].nx) : 16'(bctx[0].nx);
    any = bctx[0].ny[15] ? 16'(-bctx[0].ny) : 16'(bctx[0].ny);
    pax = 53'(sa) * 53'(anx);
    pay = 53'(sa) * 53'(any);
    pbx = 53'(sb) * 53'(anx);
    pby = 53'(sb) * 53'(any);
  end

  always_ff @(posedge clk) begin
    if (en[B0+1]) begin
      bctx[1] <= bctx[0];
      dax <= bctx[0].nx[15] ? -41'(pax[52:14]) : 41'(pax[52:14]);
      day <= bctx[0].ny[15] ? -41'(pay[52:14]) : 41'(pay[52:14]);
      dbx <= bctx[0].nx[15] ? -41'(pbx[52:14]) : 41'(pbx[52:14]);
      dby <= bctx[0].ny[15] ? -41'(pby[52:14]) : 41'(pby[52:14]);
    end
  end

  // --- back 2: apply, saturate, output register
  function automatic logic signed [31:0] sat32(input logic signed [41:0] x);
    logic signed [31:0] r;
    if (x > 42'sd2147483647)       r = 32'sh7FFFFFFF;
    else if (x < -42'sd2147483648) r = 32'sh80000000;
    else                           r = x[31:0];
    return r;
  endfunction

  logic signed [41:0] sax, say, sbx, sby;
  always_comb begin
    sax = 42'(bctx[1].vax) + (bctx[1].take ? 42'(dax) : 42'sd0);
    say = 42'(bctx[1].vay) + (bctx[1].take ? 42'(day) : 42'sd0);
    sbx = 42'(bctx[1].vbx) - (bctx[1].take ? 42'(dbx) : 42'sd0);
    sby = 42'(bctx[1].vby) - (bctx[1].take ? 42'(dby) : 42'sd0);
  end

  always_ff @(posedge clk) begin
    if (en[NST-1]) begin
      new_vel_a_x     <= sat32(sax);
      new_vel_a_y     <= sat32(say);
      new_vel_b_x     <= bctx[1].second ? sat32(sbx) : '0;
      new_vel_b_y     <= bctx[1].second ? sat32(sby) : '0;
      impulse_applied <= bctx[1].take;
    end
  end

endmodule

### rtl/core/pci_checker.sv
// ----------------------------------------------------------------------------
// pci_checker
// Port-level checks on the particle contact impulse block.
// ----------------------------------------------------------------------------
`include "particle_contact_impulse_defines.svh"

module pci_checker (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_stall,
  input logic               rsp_valid,
  input logic               rsp_stall,
  input logic signed [31:0] new_vel_a_x,
  input logic signed [31:0] new_vel_b_y,
  input logic               impulse_applied
);

  // held result keeps its value while stalled
  `PCI_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(new_vel_a_x) && $stable(new_vel_b_y) && $stable(impulse_applied), "stalled result changed")

  // request back-pressure only when the output is full and held
  `PCI_ASSERT_IMP(a_req_stall, req_stall, rsp_valid && rsp_stall, "request stalled with room in pipe")

  // no result right after reset
  `PCI_ASSERT_IMP(a_rst_empty, $past(rst), !rsp_valid, "result out of reset")

  // an empty output stage never stalls a request
  `PCI_ASSERT_IMP(a_free_pipe, !rsp_valid && req_valid, !req_stall, "stall with empty output")

endmodule

bind particle_contact_impulse pci_checker u_pci_checker (.*);
